/* rtl/core/rsa_pkg.sv */
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared constants for the character modular-exponentiation cipher: the
// character mapping offsets, the configuration register indexes and the item action codes.
// ----------------------------------------------------------------------------
package rsa_pkg;

  // Character mapping
  localparam int unsigned CHAR_OFFSET = 63;  // '?'
  localparam int unsigned SPACE_CODE  = 28;
  localparam int unsigned SPACE_CHAR  = 32;  // ' '

  // Configuration register indexes
  localparam int unsigned REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_PUB_EXP  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PRIV_EXP = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MODULUS  = 2'd2;

  // Item action codes
  localparam logic ACT_ENCRYPT = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;

endpackage

/* rtl/core/rsa_char_modexp_cipher_unit.sv */
// ----------------------------------------------------------------------------
// rsa_char_modexp_cipher_unit
// Sequence: the operand is first reduced mod n; then for each exponent bit up
//   to its highest set one, a square, preceded by a multiply if the bit is
//   set; then the power is decoded and the result word registered.
// Throughput: one word at a time, set by the single bit-serial mod-n
//   multiplier that every reduction, multiply and square shares.
// Reset: asynchronous, active low; registers return to e=17, d=2753, n=3233.
// ----------------------------------------------------------------------------
// Toy RSA over characters: encrypt maps a character to a code and returns
// code^e mod n, decrypt returns c^d mod n mapped back to a character.
// Exponentiation is square-and-multiply, exponent LSB first.
// ----------------------------------------------------------------------------
module rsa_char_modexp_cipher_unit #(
  parameter int unsigned WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [rsa_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  logic [WIDTH-1:0]             cfg_data_i,
  // input words
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         action_i,
  input  logic [WIDTH-1:0]             value_i,
  // result words
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [WIDTH-1:0]             result_o
);

  import rsa_pkg::*;

  localparam int unsigned TW = WIDTH + 2;
  localparam int unsigned CW = $clog2(WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_DECIDE,
    S_MUL_ACC,
    S_MUL_SQ,
    S_OUTPUT
  } state_e;

  state_e            state_q;
  logic [WIDTH-1:0]  pub_exp_q, priv_exp_q, mod_q;
  logic              action_q, negate_q;
  logic [WIDTH-1:0]  exp_q, acc_q, sq_q;
  logic [WIDTH-1:0]  mul_a_q, mul_b_q, mul_r_q;
  logic [CW-1:0]     cnt_q;
  logic              out_valid_q;
  logic [WIDTH-1:0]  out_result_q;

  // Effective modulus: below two counts as one
  logic [WIDTH-1:0] n_eff, one_n;
  assign n_eff = (mod_q < WIDTH'(2)) ? WIDTH'(1) : mod_q;
  assign one_n = (n_eff == WIDTH'(1)) ? '0 : WIDTH'(1);

  // Operand selection for a new word
  logic [WIDTH-1:0] op_x;
  logic             op_neg;
  always_comb begin
    op_x   = value_i;
    op_neg = 1'b0;
    if (action_i == ACT_ENCRYPT) begin
      if (value_i == WIDTH'(SPACE_CHAR)) begin
        op_x = WIDTH'(SPACE_CODE);
      end else if (value_i >= WIDTH'(CHAR_OFFSET)) begin
        op_x = value_i - WIDTH'(CHAR_OFFSET);
      end else begin
        op_x   = WIDTH'(CHAR_OFFSET) - value_i;
        op_neg = 1'b1;
      end
    end
  end

  // Shared multiplier step: r <= (2r + a_msb*b) mod n, with r, b below n
  logic [TW-1:0]    mul_t, n1, n2;
  logic [WIDTH-1:0] mul_r_d;
  logic             mul_last;
  assign n1    = TW'(n_eff);
  assign n2    = {1'b0, n_eff, 1'b0};
  assign mul_t = {1'b0, mul_r_q, 1'b0} + (mul_a_q[WIDTH-1] ? TW'(mul_b_q) : '0);
  always_comb begin
    priority if (mul_t >= n2) begin
      mul_r_d = WIDTH'(mul_t - n2);
    end else if (mul_t >= n1) begin
      mul_r_d = WIDTH'(mul_t - n1);
    end else begin
      mul_r_d = WIDTH'(mul_t);
    end
  end
  assign mul_last = (cnt_q == '0);

  // Residue of a negative code
  logic [WIDTH-1:0] base_d;
  assign base_d = (negate_q && (mul_r_d != '0)) ? (n_eff - mul_r_d) : mul_r_d;

  // Character decode of the finished power (decrypt only; encrypt passes it through)
  logic [WIDTH-1:0] res_d;
  always_comb begin
    if (action_q == ACT_ENCRYPT) begin
      res_d = acc_q;
    end else if (acc_q == WIDTH'(SPACE_CODE)) begin
      res_d = WIDTH'(SPACE_CHAR);
    end else begin
      res_d = acc_q + WIDTH'(CHAR_OFFSET);
    end
  end

  // Sequencer, datapath and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pub_exp_q    <= WIDTH'(17);
      priv_exp_q   <= WIDTH'(2753);
      mod_q        <= WIDTH'(3233);
      action_q     <= ACT_ENCRYPT;
      negate_q     <= 1'b0;
      exp_q        <= '0;
      acc_q        <= '0;
      sq_q         <= '0;
      mul_a_q      <= '0;
      mul_b_q      <= '0;
      mul_r_q      <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      out_result_q <= '0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_PUB_EXP:  pub_exp_q  <= cfg_data_i;
          REG_PRIV_EXP: priv_exp_q <= cfg_data_i;
          REG_MODULUS:  mod_q      <= cfg_data_i;
          default: ;
        endcase
      end

      // result word taken; a new word in the output state replaces it
      if (out_valid_q && !out_stall_i && state_q != S_OUTPUT) begin
        out_valid_q <= 1'b0;
      end

      // multiplier steps in every multiply state, up to its last step
      if ((state_q == S_REDUCE || state_q == S_MUL_ACC || state_q == S_MUL_SQ)
          && !mul_last) begin
        mul_r_q <= mul_r_d;
        mul_a_q <= {mul_a_q[WIDTH-2:0], 1'b0};
        cnt_q   <= cnt_q - CW'(1);
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            action_q <= action_i;
            negate_q <= op_neg;
            exp_q    <= (action_i == ACT_ENCRYPT) ? pub_exp_q : priv_exp_q;
            mul_a_q  <= op_x;
            mul_b_q  <= one_n;
            mul_r_q  <= '0;
            cnt_q    <= CW'(WIDTH - 1);
            state_q  <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          if (mul_last) begin
            sq_q    <= base_d;
            acc_q   <= one_n;
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          mul_r_q <= '0;
          cnt_q   <= CW'(WIDTH - 1);
          if (exp_q == '0) begin
            state_q <= S_OUTPUT;
          end else if (exp_q[0]) begin
            mul_a_q <= acc_q;
            mul_b_q <= sq_q;
            state_q <= S_MUL_ACC;
          end else begin
            mul_a_q <= sq_q;
            mul_b_q <= sq_q;
            state_q <= S_MUL_SQ;
          end
        end
        S_MUL_ACC: begin
          if (mul_last) begin
            acc_q   <= mul_r_d;
            mul_a_q <= sq_q;
            mul_b_q <= sq_q;
            mul_r_q <= '0;
            cnt_q   <= CW'(WIDTH - 1);
            state_q <= S_MUL_SQ;
          end
        end
        S_MUL_SQ: begin
          if (mul_last) begin
            sq_q    <= mul_r_d;
            exp_q   <= exp_q >> 1;
            state_q <= S_DECIDE;
          end
        end
        S_OUTPUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_result_q <= res_d;
            out_valid_q  <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign result_o    = out_result_q;

endmodule

/* verif/tb_rsa_char_modexp_cipher_unit.sv */
// ----------------------------------------------------------------------------
// tb_rsa_char_modexp_cipher_unit
// Self-checking bench for the character RSA cipher unit. A directed table
// covers the character mapping edges, wrap of the decrypted character,
// degenerate moduli, zero exponents and the spare register index. Random
// phases with fresh keys follow. Every result word is compared in order
// against the table's expected value or a square-and-multiply predictor.
// ----------------------------------------------------------------------------
module tb_rsa_char_modexp_cipher_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rsa_pkg::*;

  localparam int unsigned WIDTH       = 16;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam int unsigned TAIL_CYCLES = 600;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_WORDS = 100;
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;  // not mapped

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic [REG_IDX_W-1:0]   idx;
    logic                   act;
    logic [WIDTH-1:0]       data;
    bit                     known;
    logic [WIDTH-1:0]       want;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [REG_IDX_W-1:0] cfg_index_i;
  logic [WIDTH-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 action_i;
  logic [WIDTH-1:0]     value_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [WIDTH-1:0]     result_o;

  // Key copy held by the predictor
  logic [WIDTH-1:0] pub_exp_q;
  logic [WIDTH-1:0] priv_exp_q;
  logic [WIDTH-1:0] modulus_q;

  logic [WIDTH-1:0] cipher_words_due[$];
  stim_row_t        directed_rows[$];
  int unsigned      word_errors;
  int unsigned      cycle_cnt;
  bit               quiet;
  bit               hold_req;

  rsa_char_modexp_cipher_unit #(
    .WIDTH(WIDTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .result_o   (result_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Square-and-multiply, exponent LSB first, every product reduced
  function automatic longint unsigned mod_power(longint unsigned base,
                                                logic [WIDTH-1:0] expo,
                                                longint unsigned n);
    longint unsigned acc;
    longint unsigned sq;
    int              i;
    acc = 1 % n;
    sq  = base % n;
    for (i = 0; i < WIDTH; i++) begin
      if (expo[i]) acc = (acc * sq) % n;
      sq = (sq * sq) % n;
    end
    return acc;
  endfunction

  // Expected result word for one input word under the current keys
  function automatic logic [WIDTH-1:0] rsa_cipher_word(logic act, logic [WIDTH-1:0] v);
    longint unsigned n;
    longint unsigned vv;
    longint unsigned code;
    longint unsigned neg;
    longint unsigned m;
    longint unsigned res;
    n  = (modulus_q < 2) ? 1 : modulus_q;
    vv = v;
    if (act == ACT_ENCRYPT) begin
      if (vv == SPACE_CHAR) begin
        code = SPACE_CODE % n;
      end else if (vv >= CHAR_OFFSET) begin
        code = (vv - CHAR_OFFSET) % n;
      end else begin
        // negative code taken as its residue
        neg  = (CHAR_OFFSET - vv) % n;
        code = (neg == 0) ? 0 : n - neg;
      end
      res = mod_power(code, pub_exp_q, n);
    end else begin
      m   = mod_power(vv % n, priv_exp_q, n);
      res = (m == SPACE_CODE) ? SPACE_CHAR : m + CHAR_OFFSET;
    end
    return res[WIDTH-1:0];
  endfunction

  // Register value biased towards the extremes
  function automatic logic [WIDTH-1:0] pick_key_value();
    case ($urandom_range(9))
      0: return '0;
      1: return WIDTH'(1);
      2: return '1;
      3: return WIDTH'(2);
      4: return WIDTH'($urandom_range(255));
      default: return WIDTH'($urandom_range(65535));
    endcase
  endfunction

  task automatic add_word(logic act, logic [WIDTH-1:0] v);
    stim_row_t r;
    r = '{ROW_WORD, '0, act, v, 1'b0, '0};
    directed_rows.insert(directed_rows.size(), r);
  endtask

  task automatic add_word_known(logic act, logic [WIDTH-1:0] v, logic [WIDTH-1:0] w);
    stim_row_t r;
    r = '{ROW_WORD, '0, act, v, 1'b1, w};
    directed_rows.insert(directed_rows.size(), r);
  endtask

  task automatic add_cfg(logic [REG_IDX_W-1:0] idx, logic [WIDTH-1:0] d);
    stim_row_t r;
    r = '{ROW_CFG, idx, 1'b0, d, 1'b0, '0};
    directed_rows.insert(directed_rows.size(), r);
  endtask

  // One register write, then a wait with write enable low that keeps writes apart
  task automatic cfg_write(logic [REG_IDX_W-1:0] idx, logic [WIDTH-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_PUB_EXP:  pub_exp_q  = d;
      REG_PRIV_EXP: priv_exp_q = d;
      REG_MODULUS:  modulus_q  = d;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Offer one word, with random idle cycles in front of it
  task automatic send_word(logic act, logic [WIDTH-1:0] v, bit known,
                           logic [WIDTH-1:0] w);
    logic [WIDTH-1:0] due;
    while (!quiet && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    value_i    <= v;
    // accepted at the first edge that sees stall low
    @(posedge clk_i iff !in_stall_o);
    due = known ? w : rsa_cipher_word(act, v);
    cipher_words_due.insert(cipher_words_due.size(), due);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_words();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (cipher_words_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    logic             act;
    logic [WIDTH-1:0] v;
    logic [WIDTH-1:0] n_lim;
    int unsigned      ph;
    int unsigned      k;
    stim_row_t        row;

    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    action_i    <= ACT_ENCRYPT;
    value_i     <= '0;
    pub_exp_q   = 17;
    priv_exp_q  = 2753;
    modulus_q   = 3233;
    quiet       = 1'b0;
    hold_req    = 1'b0;

    // Directed table, reset keys first (e=17, d=2753, n=3233)
    add_word_known(ACT_ENCRYPT, WIDTH'(CHAR_OFFSET), 0);      // code zero
    add_word_known(ACT_ENCRYPT, 64, 1);
    add_word_known(ACT_ENCRYPT, 65, 1752);                    // 2^17 mod 3233
    add_word_known(ACT_DECRYPT, 1752, 65);
    add_word_known(ACT_DECRYPT, 0, WIDTH'(CHAR_OFFSET));
    add_word_known(ACT_DECRYPT, 1, 64);
    add_word_known(ACT_DECRYPT, 3233, WIDTH'(CHAR_OFFSET));   // word equal to n
    add_word(ACT_ENCRYPT, WIDTH'(SPACE_CHAR));
    add_word(ACT_ENCRYPT, 0);                                 // negative codes
    add_word(ACT_ENCRYPT, 62);
    add_word(ACT_ENCRYPT, 16'hFFFF);
    add_word(ACT_DECRYPT, 16'hFFFF);
    // identity decrypt key: space code and plain offset
    add_cfg(REG_PRIV_EXP, 1);
    add_word_known(ACT_DECRYPT, WIDTH'(SPACE_CODE), WIDTH'(SPACE_CHAR));
    add_word_known(ACT_DECRYPT, 3232, WIDTH'(3232 + CHAR_OFFSET));
    // zero exponents
    add_cfg(REG_PUB_EXP, 0);
    add_word_known(ACT_ENCRYPT, 100, 1);
    add_cfg(REG_PRIV_EXP, 0);
    add_word_known(ACT_DECRYPT, 5, WIDTH'(1 + CHAR_OFFSET));
    // modulus zero and one act as one
    add_cfg(REG_MODULUS, 0);
    add_word_known(ACT_ENCRYPT, 65, 0);
    add_word_known(ACT_DECRYPT, 1234, WIDTH'(CHAR_OFFSET));
    add_cfg(REG_MODULUS, 1);
    add_word_known(ACT_ENCRYPT, WIDTH'(SPACE_CHAR), 0);
    add_word_known(ACT_DECRYPT, 16'hFFFF, WIDTH'(CHAR_OFFSET));
    // widest keys; decrypted character wraps
    add_cfg(REG_MODULUS, 16'hFFFF);
    add_cfg(REG_PUB_EXP, 16'hFFFF);
    add_cfg(REG_PRIV_EXP, 1);
    add_word_known(ACT_DECRYPT, 16'hFFFE, WIDTH'(16'hFFFE + CHAR_OFFSET));
    add_word(ACT_ENCRYPT, 16'hFFFF);
    add_word(ACT_ENCRYPT, 0);
    // spare index must not land on the modulus
    add_cfg(REG_SPARE, 0);
    add_word_known(ACT_DECRYPT, WIDTH'(SPACE_CODE), WIDTH'(SPACE_CHAR));
    // back to the reset keys
    add_cfg(REG_PUB_EXP, 17);
    add_cfg(REG_PRIV_EXP, 2753);
    add_cfg(REG_MODULUS, 3233);

    // Reset
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        if (in_valid_i || cipher_words_due.size() != 0) drain_words();
        cfg_write(row.idx, row.data);
      end else begin
        send_word(row.act, row.data, row.known, row.want);
      end
    end

    // Random phases, fresh keys at each boundary
    for (ph = 0; ph < PHASES; ph++) begin
      drain_words();
      if (ph > 0) begin
        cfg_write(REG_PUB_EXP, pick_key_value());
        cfg_write(REG_PRIV_EXP, pick_key_value());
        cfg_write(REG_MODULUS, pick_key_value());
        if ($urandom_range(2) == 0) cfg_write(REG_SPARE, WIDTH'($urandom_range(65535)));
      end
      quiet = (ph == 4 || ph == 5);
      for (k = 0; k < PHASE_WORDS; k++) begin
        if (ph == 2 && k == 50) hold_req = 1'b1;
        if (ph == 6 && k == 30) drain_words();
        act = 1'($urandom_range(1));
        if (act == ACT_ENCRYPT) begin
          case ($urandom_range(9))
            0: v = WIDTH'(SPACE_CHAR);
            1, 2, 3, 4, 5: v = WIDTH'($urandom_range(126, 32));
            6: v = WIDTH'($urandom_range(62));
            default: v = WIDTH'($urandom_range(65535));
          endcase
        end else begin
          n_lim = (modulus_q < 2) ? '0 : modulus_q - WIDTH'(1);
          case ($urandom_range(9))
            0, 1, 2, 3, 4, 5, 6: v = WIDTH'($urandom_range(n_lim));
            7: v = modulus_q;
            default: v = WIDTH'($urandom_range(65535));
          endcase
        end
        send_word(act, v, 1'b0, '0);
      end
    end

    quiet = 1'b0;
    drain_words();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (word_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Result side stall: random, one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left   = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req    = 1'b0;
        hold_left   = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < 13);
      end
    end
  end

  // Result check, in order
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cipher_words_due.size() == 0) begin
        $error("result: unexpected word %0d", result_o);
        word_errors++;
      end else begin
        if (result_o !== cipher_words_due[0]) begin
          $error("result: expected %0d, got %0d", cipher_words_due[0], result_o);
          word_errors++;
        end
        void'(cipher_words_due.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    word_errors = 0;
    cycle_cnt   = 0;
  end

endmodule
